>>> hw/rtl/rar_pkg.sv
// shared types and constants for the rational arithmetic reduce block
package rar_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int IO_WIDTH   = 32;
    localparam int CNT_WIDTH  = $clog2(DATA_WIDTH + 1);

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [CNT_WIDTH-1:0]  cnt_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_DIV = 2'd2,
        OP_RSV = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_GCD,
        ST_DIV_INIT,
        ST_DIV,
        ST_SIGN,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic sum;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic sign_fix;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic gcd_done;
        logic div_done;
    } dp_sts_t;

endpackage

>>> hw/rtl/rational_arith_reduce_core.sv
// Rational arithmetic with gcd reduction, top level.
// Input beat: operation with a_num/a_den and b_num/b_den, taken on
// in_valid && in_ready. Output beat: res_num/res_den and undefined,
// taken on out_valid && out_ready. Exactly one output beat per input beat.
// operation 0 adds, 1 multiplies, 2 and 3 divide first by second; all
// products wrap at DATA_WIDTH bits.
// One item at a time: in_ready is high only while the core is idle.
// Order of work: multiply and sum states, then a Euclid gcd where each
// remainder is formed bit by bit on a bit-serial subtractor (up to
// about 45 remainders at 32 bits) plus a step to see the zero, then
// the two restoring dividers that divide both parts by the gcd,
// then the sign step, after which out_valid rises.
// The next input beat can be taken from the cycle after the output beat on.
// When both raw parts are zero, undefined is set and both parts are zero.
// Reset returns the controller to idle; no output beat is pending after it.
// A stalled receiver holds the result and the core takes no new beat.
module rational_arith_reduce_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] a_num,
    input  logic [31:0] a_den,
    input  logic [31:0] b_num,
    input  logic [31:0] b_den,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] res_num,
    output logic [31:0] res_den,
    output logic        undefined
);
    import rar_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    busy;
    logic    done;
    logic    in_fire;
    logic    out_stage;

    assign in_ready  = !busy;
    assign in_fire   = in_valid && in_ready;

    rar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_ready),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    rar_datapath u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .operation (operation),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .sts       (sts),
        .res_num   (res_num),
        .res_den   (res_den),
        .undefined (undefined)
    );

    assign out_stage = busy && !(cmd.load | cmd.mul1 | cmd.mul2 | cmd.sum | cmd.gcd_step
                                 | cmd.div_init | cmd.div_step | cmd.sign_fix);
    assign out_valid = out_stage;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !out_valid) else $error("result repeated");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> busy) else $error("core not busy after input beat");
`endif

endmodule

>>> hw/rtl/rar_ctrl.sv
// controller state machine for the rational arithmetic reduce block
module rar_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic             out_free,
    input  rar_pkg::dp_sts_t sts,
    output rar_pkg::dp_cmd_t cmd,
    output logic             busy,
    output logic             done
);
    import rar_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_fire) state_next = ST_MUL1;
            ST_MUL1:     state_next = ST_MUL2;
            ST_MUL2:     state_next = ST_SUM;
            ST_SUM:      state_next = ST_GCD;
            ST_GCD:      if (sts.gcd_done) state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV:      if (sts.div_done) state_next = ST_SIGN;
            ST_SIGN:     state_next = ST_OUT;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == ST_IDLE) && in_fire;
        cmd.mul1     = (state_reg == ST_MUL1);
        cmd.mul2     = (state_reg == ST_MUL2);
        cmd.sum      = (state_reg == ST_SUM);
        cmd.gcd_step = (state_reg == ST_GCD);
        cmd.div_init = (state_reg == ST_DIV_INIT);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.sign_fix = (state_reg == ST_SIGN);
        busy         = (state_reg != ST_IDLE);
        done         = (state_reg == ST_OUT) && out_free;
    end

endmodule

>>> hw/rtl/rar_datapath.sv
// cross products, euclid gcd and restoring dividers
module rar_datapath (
    input  logic             clk,
    input  rar_pkg::dp_cmd_t cmd,
    input  logic [1:0]       operation,
    input  logic [31:0]      a_num,
    input  logic [31:0]      a_den,
    input  logic [31:0]      b_num,
    input  logic [31:0]      b_den,
    output rar_pkg::dp_sts_t sts,
    output logic [31:0]      res_num,
    output logic [31:0]      res_den,
    output logic             undefined
);
    import rar_pkg::*;

    word_t an_reg, ad_reg, bn_reg, bd_reg;
    logic  div_op_reg, add_op_reg;
    word_t p0_reg, p1_reg, p2_reg;
    word_t rn_reg, rd_reg;
    word_t gx_reg, gy_reg, gx_next, gy_next;
    // gcd done when the second value reaches zero; one remainder bit a cycle
    word_t rem_reg;
    cnt_t  gcnt_reg;
    logic  gact_reg;
    word_t qn_reg, qd_reg, ren_reg, red_reg;
    cnt_t  dcnt_reg;
    logic  und_reg;

    function automatic word_t mag(input word_t v);
        mag = v[DATA_WIDTH-1] ? (~v + word_t'(1)) : v;
    endfunction

    // restoring trials: gcd remainder x mod y, serial over x; dividers by x
    logic [DATA_WIDTH:0] gtrial;
    logic [DATA_WIDTH:0] ntrial, dtrial;
    always_comb
    begin
        gtrial = {rem_reg, gx_reg[DATA_WIDTH-1]} - {1'b0, gy_reg};
        ntrial = {ren_reg, qn_reg[DATA_WIDTH-1]} - {1'b0, gx_reg};
        dtrial = {red_reg, qd_reg[DATA_WIDTH-1]} - {1'b0, gx_reg};
        gx_next = gx_reg;
        gy_next = gy_reg;
    end

    assign sts.gcd_done = (gy_reg == '0) && !gact_reg;
    assign sts.div_done = (dcnt_reg == cnt_t'(DATA_WIDTH));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            an_reg     <= a_num[DATA_WIDTH-1:0];
            ad_reg     <= a_den[DATA_WIDTH-1:0];
            bn_reg     <= b_num[DATA_WIDTH-1:0];
            bd_reg     <= b_den[DATA_WIDTH-1:0];
            div_op_reg <= operation[1];
            add_op_reg <= (operation == OP_ADD);
        end
        if (cmd.mul1)
        begin
            p0_reg <= word_t'(an_reg * (div_op_reg ? bd_reg : (add_op_reg ? bd_reg : bn_reg)));
            p2_reg <= word_t'(ad_reg * (div_op_reg ? bn_reg : bd_reg));
        end
        if (cmd.mul2)
        begin
            p1_reg <= word_t'(ad_reg * bn_reg);
        end
        if (cmd.sum)
        begin
            rn_reg   <= add_op_reg ? (p0_reg + p1_reg) : p0_reg;
            rd_reg   <= p2_reg;
            gx_reg   <= mag(add_op_reg ? (p0_reg + p1_reg) : p0_reg);
            gy_reg   <= mag(p2_reg);
            gact_reg <= 1'b0;
        end
        if (cmd.gcd_step)
        begin
            if (!gact_reg)
            begin
                if (gy_reg != '0)
                begin
                    gact_reg <= 1'b1;
                    gcnt_reg <= '0;
                    rem_reg  <= '0;
                end
            end
            else
            begin
                // shift x through the remainder; y ends holding the next remainder, x the old y
                if (!gtrial[DATA_WIDTH])
                    rem_reg <= gtrial[DATA_WIDTH-1:0];
                else
                    rem_reg <= {rem_reg[DATA_WIDTH-2:0], gx_reg[DATA_WIDTH-1]};
                gcnt_reg <= gcnt_reg + cnt_t'(1);
                if (gcnt_reg == cnt_t'(DATA_WIDTH - 1))
                begin
                    gact_reg <= 1'b0;
                    gx_reg   <= gy_next;
                    gy_reg   <= (!gtrial[DATA_WIDTH]) ? gtrial[DATA_WIDTH-1:0]
                                : {rem_reg[DATA_WIDTH-2:0], gx_reg[DATA_WIDTH-1]};
                end
                else
                begin
                    gx_reg   <= {gx_next[DATA_WIDTH-2:0], 1'b0};
                end
            end
        end
        if (cmd.div_init)
        begin
            und_reg  <= (gx_reg == '0);
            qn_reg   <= mag(rn_reg);
            qd_reg   <= mag(rd_reg);
            ren_reg  <= '0;
            red_reg  <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_step && !sts.div_done)
        begin
            ren_reg <= ntrial[DATA_WIDTH] ? {ren_reg[DATA_WIDTH-2:0], qn_reg[DATA_WIDTH-1]}
                       : ntrial[DATA_WIDTH-1:0];
            red_reg <= dtrial[DATA_WIDTH] ? {red_reg[DATA_WIDTH-2:0], qd_reg[DATA_WIDTH-1]}
                       : dtrial[DATA_WIDTH-1:0];
            qn_reg  <= {qn_reg[DATA_WIDTH-2:0], ~ntrial[DATA_WIDTH]};
            qd_reg  <= {qd_reg[DATA_WIDTH-2:0], ~dtrial[DATA_WIDTH]};
            dcnt_reg <= dcnt_reg + cnt_t'(1);
        end
        if (cmd.sign_fix)
        begin
            qn_reg <= und_reg ? '0 : (rn_reg[DATA_WIDTH-1] ? (~qn_reg + word_t'(1)) : qn_reg);
            qd_reg <= und_reg ? '0 : (rd_reg[DATA_WIDTH-1] ? (~qd_reg + word_t'(1)) : qd_reg);
        end
    end

    assign res_num   = IO_WIDTH'(signed'(qn_reg));
    assign res_den   = IO_WIDTH'(signed'(qd_reg));
    assign undefined = und_reg;

endmodule
